@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL folder.
// Expects clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define TCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define TCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tcl_pkg.sv @@
// Package for the blended triangle centre pipeline: request and result types,
// derived widths and fixed constants. Depends on nothing.
package tcl_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int BLEND_FRAC_BITS = 16;
  localparam int BLEND_WIDTH     = BLEND_FRAC_BITS + 1;

  // vertex differences, coordinate sums, squares, determinant, numerators
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int SUM_WIDTH  = COORD_WIDTH + 2;
  localparam int SQ_WIDTH   = 2 * DIFF_WIDTH;
  localparam int PP_WIDTH   = 2 * DIFF_WIDTH + 1;
  localparam int DET_WIDTH  = 2 * DIFF_WIDTH + 1;
  localparam int NUM_WIDTH  = DIFF_WIDTH + SQ_WIDTH + 1;

  // quotient bits kept by the divider, offset and blend widths
  localparam int QUO_WIDTH = COORD_WIDTH + BLEND_FRAC_BITS + 3;
  localparam int POS_WIDTH = QUO_WIDTH + 2;
  localparam int MAG_SPLIT = COORD_WIDTH;
  localparam int LO_PW     = MAG_SPLIT + BLEND_WIDTH;
  localparam int HI_PW     = POS_WIDTH - MAG_SPLIT + BLEND_WIDTH;
  localparam int PROD_WIDTH = POS_WIDTH + BLEND_WIDTH + 1;
  localparam int RES_WIDTH = POS_WIDTH + 3;

  localparam logic [BLEND_WIDTH-1:0] BLEND_ONE = BLEND_WIDTH'(1) << BLEND_FRAC_BITS;
  localparam logic [QUO_WIDTH-1:0] QUO_LIM = QUO_WIDTH'(1) << (QUO_WIDTH - 1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // ceil(2^(SUM_WIDTH+2) / 3): floor(x / 3) = (x * RECIP3) >> (SUM_WIDTH + 2)
  localparam logic [SUM_WIDTH:0] RECIP3 =
    (SUM_WIDTH+1)'(((65'd1 << (SUM_WIDTH + 2)) + 65'd2) / 65'd3);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic [BLEND_WIDTH-1:0]        blend;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic                          degenerate;
    logic                          saturated;
  } out_t;

endpackage

@@ sv/triangle_center_lerp.sv @@
// Blended triangle centre: circumcentre moved toward the centroid by a factor.
// Depends on tcl_pkg and assert_macros.svh.
//
//  port group  | dir | payload     | handshake
//  in_*        | in  | tcl_pkg::in_t  | in_valid / in_stall
//  out_*       | out | tcl_pkg::out_t | out_valid / out_stall
//
// One request enters per cycle while no result is stalled at the output. Most
// of the stages belong to the restoring divider, which yields one quotient bit
// per stage. Reset clears only the stage valid bits.
// A stalled result at the output holds the whole pipeline in place.

`include "assert_macros.svh"

module triangle_center_lerp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tcl_pkg::out_t out_data
);

  localparam int W  = tcl_pkg::COORD_WIDTH;
  localparam int DW = tcl_pkg::DIFF_WIDTH;
  localparam int SW = tcl_pkg::SUM_WIDTH;
  localparam int QW = tcl_pkg::QUO_WIDTH;
  localparam int PW = tcl_pkg::POS_WIDTH;
  localparam int NW = tcl_pkg::NUM_WIDTH;
  localparam int EW = tcl_pkg::DET_WIDTH;
  localparam int BW = tcl_pkg::BLEND_WIDTH;
  localparam int RW = tcl_pkg::RES_WIDTH;
  localparam int XW = tcl_pkg::PROD_WIDTH;

  typedef struct packed {
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] gx;
    logic signed [W-1:0] gy;
    logic [BW-1:0]       blend;
  } base_t;

  typedef struct packed {
    base_t base;
    logic  degen;
  } side_t;

  typedef struct packed {
    logic signed [W-1:0]  ax;
    logic signed [W-1:0]  ay;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] ey;
    logic                 gxneg;
    logic                 gyneg;
    logic [SW-1:0]        gxm;
    logic [SW-1:0]        gym;
    logic [BW-1:0]        blend;
  } s1_t;

  typedef struct packed {
    base_t                                 base;
    logic signed [DW-1:0]                  dx;
    logic signed [DW-1:0]                  dy;
    logic signed [DW-1:0]                  ex;
    logic signed [DW-1:0]                  ey;
    logic signed [tcl_pkg::SQ_WIDTH-1:0]   dxey;
    logic signed [tcl_pkg::SQ_WIDTH-1:0]   dyex;
    logic [tcl_pkg::SQ_WIDTH-1:0]          sqdx;
    logic [tcl_pkg::SQ_WIDTH-1:0]          sqdy;
    logic [tcl_pkg::SQ_WIDTH-1:0]          sqex;
    logic [tcl_pkg::SQ_WIDTH-1:0]          sqey;
  } s2_t;

  typedef struct packed {
    base_t                        base;
    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
    logic signed [DW-1:0]         ex;
    logic signed [DW-1:0]         ey;
    logic signed [EW-1:0]         det;
    logic [tcl_pkg::SQ_WIDTH-1:0] lb;
    logic [tcl_pkg::SQ_WIDTH-1:0] lc;
  } s3_t;

  typedef struct packed {
    base_t                                base;
    logic signed [EW-1:0]                 det;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  eyb_lo;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  eyb_hi;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  dyc_lo;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  dyc_hi;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  dxc_lo;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  dxc_hi;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  exb_lo;
    logic signed [tcl_pkg::PP_WIDTH-1:0]  exb_hi;
  } s4_t;

  typedef struct packed {
    base_t                base;
    logic signed [EW-1:0] det;
    logic signed [NW-1:0] eyb;
    logic signed [NW-1:0] dyc;
    logic signed [NW-1:0] dxc;
    logic signed [NW-1:0] exb;
  } s5_t;

  typedef struct packed {
    base_t                base;
    logic signed [EW-1:0] det;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
  } s6_t;

  typedef struct packed {
    logic [QW-1:0] low;
    logic [EW-1:0] rem;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } div_t;

  typedef struct packed {
    side_t         side;
    logic [EW-1:0] dd;
    div_t          x;
    div_t          y;
  } dst_t;

  typedef struct packed {
    side_t               side;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
  } b1_t;

  typedef struct packed {
    side_t                side;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic [PW-1:0]        mdx;
    logic [PW-1:0]        mdy;
    logic                 negx;
    logic                 negy;
  } b2_t;

  typedef struct packed {
    side_t                side;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic                 negx;
    logic                 negy;
    logic [tcl_pkg::LO_PW-1:0] lox;
    logic [tcl_pkg::HI_PW-1:0] hix;
    logic [tcl_pkg::LO_PW-1:0] loy;
    logic [tcl_pkg::HI_PW-1:0] hiy;
  } b3_t;

  typedef struct packed {
    side_t                side;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic                 negx;
    logic                 negy;
    logic [PW:0]          tx;
    logic [PW:0]          ty;
  } b4_t;

  // One restoring step: bring down the next numerator bit, subtract if it fits
  function automatic div_t div_step(div_t c, logic [EW-1:0] dd);
    div_t        r;
    logic [EW:0] t;
    r     = c;
    t     = {c.rem, c.low[QW-1]};
    r.low = c.low << 1;
    if (t >= {1'b0, dd}) begin
      t   = t - {1'b0, dd};
      r.q = {c.q[QW-2:0], 1'b1};
    end else begin
      r.q = {c.q[QW-2:0], 1'b0};
    end
    r.rem = t[EW-1:0];
    return r;
  endfunction

  // Set up round(|num| / (2|d|)): divide |num| + |d| by 2|d|
  function automatic div_t div_init(logic signed [NW-1:0] num, logic dneg,
                                    logic [EW-1:0] dmag, logic [EW-1:0] dd);
    div_t          r;
    logic [NW-1:0] nm;
    logic [NW-1:0] n;
    logic [NW-1:0] top;
    nm    = num[NW-1] ? NW'(-num) : NW'(num);
    n     = nm + NW'(dmag);
    top   = n >> QW;
    r.ovf = top >= NW'(dd);
    r.rem = EW'(top);
    r.low = n[QW-1:0];
    r.q   = '0;
    r.neg = num[NW-1] != dneg;
    return r;
  endfunction

  function automatic dst_t div_stage(dst_t c);
    dst_t r;
    r   = c;
    r.x = div_step(c.x, c.dd);
    r.y = div_step(c.y, c.dd);
    return r;
  endfunction

  // Offset p by the rounded blend step, then clip to the coordinate range
  function automatic logic [W:0] blend_axis(logic signed [PW-1:0] p, logic neg,
                                            logic [PW:0] t);
    logic signed [RW-1:0] r;
    logic                 sat;
    logic signed [W-1:0]  v;
    r = neg ? RW'(p) - $signed(RW'(t)) : RW'(p) + $signed(RW'(t));
    if (r > RW'(tcl_pkg::COORD_MAX)) begin
      sat = 1'b1;
      v   = tcl_pkg::COORD_MAX;
    end else if (r < RW'(tcl_pkg::COORD_MIN)) begin
      sat = 1'b1;
      v   = tcl_pkg::COORD_MIN;
    end else begin
      sat = 1'b0;
      v   = W'(r);
    end
    return {sat, v};
  endfunction

  logic         adv;
  logic [5:0]   fv_r;
  logic [QW:0]  vd_r;
  logic [3:0]   bv_r;
  logic         vout_r;

  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  s4_t   s4_r, s4_nxt;
  s5_t   s5_r, s5_nxt;
  s6_t   s6_r, s6_nxt;
  dst_t  dst0_nxt;
  dst_t  dst_r   [QW+1];
  dst_t  dst_nxt [QW+1];
  b1_t   b1_r, b1_nxt;
  b2_t   b2_r, b2_nxt;
  b3_t   b3_r, b3_nxt;
  b4_t   b4_r, b4_nxt;
  tcl_pkg::out_t out_r, out_nxt;

  // Hold everything while a finished result waits
  assign adv       = !(vout_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vout_r;
  assign out_data  = out_r;

  // Stage 1: differences, centroid sums, blend clamp
  always_comb begin : st1
    logic signed [SW-1:0] sx, sy;
    sx = SW'(in_data.a_x) + SW'(in_data.b_x) + SW'(in_data.c_x);
    sy = SW'(in_data.a_y) + SW'(in_data.b_y) + SW'(in_data.c_y);
    s1_nxt.ax    = in_data.a_x;
    s1_nxt.ay    = in_data.a_y;
    s1_nxt.dx    = DW'(in_data.b_x) - DW'(in_data.a_x);
    s1_nxt.dy    = DW'(in_data.b_y) - DW'(in_data.a_y);
    s1_nxt.ex    = DW'(in_data.c_x) - DW'(in_data.a_x);
    s1_nxt.ey    = DW'(in_data.c_y) - DW'(in_data.a_y);
    s1_nxt.gxneg = sx[SW-1];
    s1_nxt.gyneg = sy[SW-1];
    s1_nxt.gxm   = (sx[SW-1] ? SW'(-sx) : SW'(sx)) + SW'(1);
    s1_nxt.gym   = (sy[SW-1] ? SW'(-sy) : SW'(sy)) + SW'(1);
    s1_nxt.blend = (in_data.blend > tcl_pkg::BLEND_ONE) ? tcl_pkg::BLEND_ONE : in_data.blend;
  end

  // Stage 2: cross and square products, centroid by reciprocal multiply
  always_comb begin : st2
    logic [2*SW:0] gpx, gpy;
    logic [W:0]    grx, gry;
    gpx = (2*SW+1)'(s1_r.gxm) * (2*SW+1)'(tcl_pkg::RECIP3);
    gpy = (2*SW+1)'(s1_r.gym) * (2*SW+1)'(tcl_pkg::RECIP3);
    grx = (W+1)'(gpx >> (SW + 2));
    gry = (W+1)'(gpy >> (SW + 2));
    s2_nxt.base.ax    = s1_r.ax;
    s2_nxt.base.ay    = s1_r.ay;
    s2_nxt.base.gx    = W'(s1_r.gxneg ? -grx : grx);
    s2_nxt.base.gy    = W'(s1_r.gyneg ? -gry : gry);
    s2_nxt.base.blend = s1_r.blend;
    s2_nxt.dx   = s1_r.dx;
    s2_nxt.dy   = s1_r.dy;
    s2_nxt.ex   = s1_r.ex;
    s2_nxt.ey   = s1_r.ey;
    s2_nxt.dxey = tcl_pkg::SQ_WIDTH'(s1_r.dx) * tcl_pkg::SQ_WIDTH'(s1_r.ey);
    s2_nxt.dyex = tcl_pkg::SQ_WIDTH'(s1_r.dy) * tcl_pkg::SQ_WIDTH'(s1_r.ex);
    s2_nxt.sqdx = tcl_pkg::SQ_WIDTH'(tcl_pkg::SQ_WIDTH'(s1_r.dx) * tcl_pkg::SQ_WIDTH'(s1_r.dx));
    s2_nxt.sqdy = tcl_pkg::SQ_WIDTH'(tcl_pkg::SQ_WIDTH'(s1_r.dy) * tcl_pkg::SQ_WIDTH'(s1_r.dy));
    s2_nxt.sqex = tcl_pkg::SQ_WIDTH'(tcl_pkg::SQ_WIDTH'(s1_r.ex) * tcl_pkg::SQ_WIDTH'(s1_r.ex));
    s2_nxt.sqey = tcl_pkg::SQ_WIDTH'(tcl_pkg::SQ_WIDTH'(s1_r.ey) * tcl_pkg::SQ_WIDTH'(s1_r.ey));
  end

  // Stage 3: determinant and squared edge lengths
  always_comb begin : st3
    s3_nxt.base = s2_r.base;
    s3_nxt.dx   = s2_r.dx;
    s3_nxt.dy   = s2_r.dy;
    s3_nxt.ex   = s2_r.ex;
    s3_nxt.ey   = s2_r.ey;
    s3_nxt.det  = EW'(s2_r.dxey) - EW'(s2_r.dyex);
    s3_nxt.lb   = s2_r.sqdx + s2_r.sqdy;
    s3_nxt.lc   = s2_r.sqex + s2_r.sqey;
  end

  // Stage 4: numerator partial products, lengths split in two halves
  always_comb begin : st4
    logic signed [tcl_pkg::PP_WIDTH-1:0] blo, bhi, clo, chi;
    blo = $signed(tcl_pkg::PP_WIDTH'(s3_r.lb[DW-1:0]));
    bhi = $signed(tcl_pkg::PP_WIDTH'(s3_r.lb[tcl_pkg::SQ_WIDTH-1:DW]));
    clo = $signed(tcl_pkg::PP_WIDTH'(s3_r.lc[DW-1:0]));
    chi = $signed(tcl_pkg::PP_WIDTH'(s3_r.lc[tcl_pkg::SQ_WIDTH-1:DW]));
    s4_nxt.base   = s3_r.base;
    s4_nxt.det    = s3_r.det;
    s4_nxt.eyb_lo = tcl_pkg::PP_WIDTH'(s3_r.ey) * blo;
    s4_nxt.eyb_hi = tcl_pkg::PP_WIDTH'(s3_r.ey) * bhi;
    s4_nxt.dyc_lo = tcl_pkg::PP_WIDTH'(s3_r.dy) * clo;
    s4_nxt.dyc_hi = tcl_pkg::PP_WIDTH'(s3_r.dy) * chi;
    s4_nxt.dxc_lo = tcl_pkg::PP_WIDTH'(s3_r.dx) * clo;
    s4_nxt.dxc_hi = tcl_pkg::PP_WIDTH'(s3_r.dx) * chi;
    s4_nxt.exb_lo = tcl_pkg::PP_WIDTH'(s3_r.ex) * blo;
    s4_nxt.exb_hi = tcl_pkg::PP_WIDTH'(s3_r.ex) * bhi;
  end

  // Stage 5: join partial products
  always_comb begin : st5
    s5_nxt.base = s4_r.base;
    s5_nxt.det  = s4_r.det;
    s5_nxt.eyb  = (NW'(s4_r.eyb_hi) <<< DW) + NW'(s4_r.eyb_lo);
    s5_nxt.dyc  = (NW'(s4_r.dyc_hi) <<< DW) + NW'(s4_r.dyc_lo);
    s5_nxt.dxc  = (NW'(s4_r.dxc_hi) <<< DW) + NW'(s4_r.dxc_lo);
    s5_nxt.exb  = (NW'(s4_r.exb_hi) <<< DW) + NW'(s4_r.exb_lo);
  end

  // Stage 6: circumcentre numerators
  always_comb begin : st6
    s6_nxt.base = s5_r.base;
    s6_nxt.det  = s5_r.det;
    s6_nxt.nx   = s5_r.eyb - s5_r.dyc;
    s6_nxt.ny   = s5_r.dxc - s5_r.exb;
  end

  // Divider set-up: magnitudes, rounding bias, overflow of the kept quotient
  always_comb begin : st_div0
    logic [EW-1:0] dmag, dd;
    dmag = s6_r.det[EW-1] ? EW'(-s6_r.det) : EW'(s6_r.det);
    dd   = dmag << 1;
    dst0_nxt.side.base  = s6_r.base;
    dst0_nxt.side.degen = (s6_r.det == '0);
    dst0_nxt.dd         = dd;
    dst0_nxt.x          = div_init(s6_r.nx, s6_r.det[EW-1], dmag, dd);
    dst0_nxt.y          = div_init(s6_r.ny, s6_r.det[EW-1], dmag, dd);
  end

  assign dst_nxt[0] = dst0_nxt;

  // Divider: one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    assign dst_nxt[k+1] = div_stage(dst_r[k]);
  end

  // Back 1: clamp quotient, form circumcentre
  always_comb begin : bk1
    logic [QW-1:0] mx, my;
    mx = (dst_r[QW].x.ovf || dst_r[QW].x.q > tcl_pkg::QUO_LIM) ? tcl_pkg::QUO_LIM
                                                              : dst_r[QW].x.q;
    my = (dst_r[QW].y.ovf || dst_r[QW].y.q > tcl_pkg::QUO_LIM) ? tcl_pkg::QUO_LIM
                                                              : dst_r[QW].y.q;
    b1_nxt.side = dst_r[QW].side;
    b1_nxt.px   = PW'(dst_r[QW].side.base.ax) +
                  (dst_r[QW].x.neg ? -$signed(PW'(mx)) : $signed(PW'(mx)));
    b1_nxt.py   = PW'(dst_r[QW].side.base.ay) +
                  (dst_r[QW].y.neg ? -$signed(PW'(my)) : $signed(PW'(my)));
  end

  // Back 2: distance to the centroid
  always_comb begin : bk2
    logic signed [PW:0] gdx, gdy;
    gdx = (PW+1)'(b1_r.side.base.gx) - (PW+1)'(b1_r.px);
    gdy = (PW+1)'(b1_r.side.base.gy) - (PW+1)'(b1_r.py);
    b2_nxt.side = b1_r.side;
    b2_nxt.px   = b1_r.px;
    b2_nxt.py   = b1_r.py;
    b2_nxt.negx = gdx[PW];
    b2_nxt.negy = gdy[PW];
    b2_nxt.mdx  = PW'(gdx[PW] ? -gdx : gdx);
    b2_nxt.mdy  = PW'(gdy[PW] ? -gdy : gdy);
  end

  // Back 3: distance times blend, split in two partial products
  always_comb begin : bk3
    b3_nxt.side = b2_r.side;
    b3_nxt.px   = b2_r.px;
    b3_nxt.py   = b2_r.py;
    b3_nxt.negx = b2_r.negx;
    b3_nxt.negy = b2_r.negy;
    b3_nxt.lox  = tcl_pkg::LO_PW'(b2_r.mdx[tcl_pkg::MAG_SPLIT-1:0]) *
                  tcl_pkg::LO_PW'(b2_r.side.base.blend);
    b3_nxt.hix  = tcl_pkg::HI_PW'(b2_r.mdx[PW-1:tcl_pkg::MAG_SPLIT]) *
                  tcl_pkg::HI_PW'(b2_r.side.base.blend);
    b3_nxt.loy  = tcl_pkg::LO_PW'(b2_r.mdy[tcl_pkg::MAG_SPLIT-1:0]) *
                  tcl_pkg::LO_PW'(b2_r.side.base.blend);
    b3_nxt.hiy  = tcl_pkg::HI_PW'(b2_r.mdy[PW-1:tcl_pkg::MAG_SPLIT]) *
                  tcl_pkg::HI_PW'(b2_r.side.base.blend);
  end

  // Back 4: join, round half up, drop the fraction bits
  always_comb begin : bk4
    logic [XW-1:0] fx, fy;
    fx = (XW'(b3_r.hix) << tcl_pkg::MAG_SPLIT) + XW'(b3_r.lox) +
         (XW'(1) << (tcl_pkg::BLEND_FRAC_BITS - 1));
    fy = (XW'(b3_r.hiy) << tcl_pkg::MAG_SPLIT) + XW'(b3_r.loy) +
         (XW'(1) << (tcl_pkg::BLEND_FRAC_BITS - 1));
    b4_nxt.side = b3_r.side;
    b4_nxt.px   = b3_r.px;
    b4_nxt.py   = b3_r.py;
    b4_nxt.negx = b3_r.negx;
    b4_nxt.negy = b3_r.negy;
    b4_nxt.tx   = (PW+1)'(fx >> tcl_pkg::BLEND_FRAC_BITS);
    b4_nxt.ty   = (PW+1)'(fy >> tcl_pkg::BLEND_FRAC_BITS);
  end

  // Output: blended point with clipping, centroid for a collinear triangle
  always_comb begin : bk5
    logic [W:0] rx, ry;
    rx = blend_axis(b4_r.px, b4_r.negx, b4_r.tx);
    ry = blend_axis(b4_r.py, b4_r.negy, b4_r.ty);
    if (b4_r.side.degen) begin
      out_nxt.center_x  = b4_r.side.base.gx;
      out_nxt.center_y  = b4_r.side.base.gy;
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.center_x  = rx[W-1:0];
      out_nxt.center_y  = ry[W-1:0];
      out_nxt.saturated = rx[W] | ry[W];
    end
    out_nxt.degenerate = b4_r.side.degen;
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= '0;
      vd_r   <= '0;
      bv_r   <= '0;
      vout_r <= 1'b0;
    end else if (adv) begin
      fv_r   <= {fv_r[4:0], in_valid};
      vd_r   <= {vd_r[QW-1:0], fv_r[5]};
      bv_r   <= {bv_r[2:0], vd_r[QW]};
      vout_r <= bv_r[3];
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      s4_r     <= s4_nxt;
      s5_r     <= s5_nxt;
      s6_r     <= s6_nxt;
      for (int k = 0; k <= QW; k++) begin
        dst_r[k] <= dst_nxt[k];
      end
      b1_r     <= b1_nxt;
      b2_r     <= b2_nxt;
      b3_r     <= b3_nxt;
      b4_r     <= b4_nxt;
      out_r    <= out_nxt;
    end
  end

  `TCL_ASSERT(a_degen_unclipped, !(vout_r && out_r.degenerate && out_r.saturated),
              "collinear result flagged as clipped")
  `TCL_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, fv_r[0],
                   "accepted request missing from first stage")
  `TCL_ASSERT_NEXT(a_stall_freezes, in_stall,
                   vd_r == $past(vd_r) && bv_r == $past(bv_r) && fv_r == $past(fv_r),
                   "pipeline moved while the output was stalled")

endmodule

@@ verif/triangle_center_lerp_tb.sv @@
// Self-checking bench for triangle_center_lerp: random and directed triangles
// go in, and each blended centre is compared with a local model. Depends on tcl_pkg.
module triangle_center_lerp_tb;

  typedef logic signed [127:0] wide_t;

  // Model of the block and the queue of centres still owed by it
  class center_scoreboard;
    tcl_pkg::out_t pending_centers[$];
    int   errors;
    int   degenerate_seen;
    int   saturated_seen;

    function wide_t mag(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    // Round n / (2d) to nearest, ties away from zero, and clamp the magnitude
    function wide_t offset_round(wide_t n, wide_t d);
      wide_t q;
      q = (mag(n) + mag(d)) / (2 * mag(d));
      if (q > (wide_t'(1) << (tcl_pkg::COORD_WIDTH + tcl_pkg::BLEND_FRAC_BITS + 2)))
        q = wide_t'(1) << (tcl_pkg::COORD_WIDTH + tcl_pkg::BLEND_FRAC_BITS + 2);
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function wide_t centroid(wide_t a, wide_t b, wide_t c);
      wide_t s, r;
      s = a + b + c;
      r = (mag(s) + 1) / 3;
      return (s < 0) ? -r : r;
    endfunction

    // Move p toward g by the blend factor, then clip to the coordinate range
    function logic signed [tcl_pkg::COORD_WIDTH-1:0] blend_clip(wide_t p, wide_t g,
                                                               wide_t bl, inout logic sat);
      wide_t diff, t, r;
      diff = g - p;
      t = (mag(diff) * bl + (wide_t'(1) << (tcl_pkg::BLEND_FRAC_BITS - 1))) >>>
          tcl_pkg::BLEND_FRAC_BITS;
      if (t > (wide_t'(1) << 62)) t = wide_t'(1) << 62;
      r = (diff < 0) ? p - t : p + t;
      if (r > wide_t'(tcl_pkg::COORD_MAX)) begin
        sat = 1'b1;
        return tcl_pkg::COORD_MAX;
      end
      if (r < wide_t'(tcl_pkg::COORD_MIN)) begin
        sat = 1'b1;
        return tcl_pkg::COORD_MIN;
      end
      return r[tcl_pkg::COORD_WIDTH-1:0];
    endfunction

    function tcl_pkg::out_t blended_center(tcl_pkg::in_t r);
      wide_t ax, ay, bx, by, cx, cy, bl;
      wide_t dx, dy, ex, ey, d, lb, lc, gx, gy, px, py;
      tcl_pkg::out_t res;
      logic sat;
      ax = r.a_x; ay = r.a_y; bx = r.b_x; by = r.b_y; cx = r.c_x; cy = r.c_y;
      bl = r.blend;
      if (bl > tcl_pkg::BLEND_ONE) bl = tcl_pkg::BLEND_ONE;
      gx = centroid(ax, bx, cx);
      gy = centroid(ay, by, cy);
      dx = bx - ax; dy = by - ay; ex = cx - ax; ey = cy - ay;
      d = dx * ey - dy * ex;
      sat = 1'b0;
      if (d == 0) begin
        res.center_x = gx[tcl_pkg::COORD_WIDTH-1:0];
        res.center_y = gy[tcl_pkg::COORD_WIDTH-1:0];
        res.degenerate = 1'b1;
      end else begin
        lb = dx * dx + dy * dy;
        lc = ex * ex + ey * ey;
        px = ax + offset_round(ey * lb - dy * lc, d);
        py = ay + offset_round(dx * lc - ex * lb, d);
        res.center_x = blend_clip(px, gx, bl, sat);
        res.center_y = blend_clip(py, gy, bl, sat);
        res.degenerate = 1'b0;
      end
      res.saturated = sat;
      return res;
    endfunction

    function void note_request(tcl_pkg::in_t r);
      pending_centers.push_back(blended_center(r));
    endfunction

    function void check_result(tcl_pkg::out_t got);
      tcl_pkg::out_t want;
      if (pending_centers.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_centers.pop_front();
      if (got.center_x !== want.center_x) begin
        $error("center_x: expected %0d, got %0d", want.center_x, got.center_x);
        errors++;
      end
      if (got.center_y !== want.center_y) begin
        $error("center_y: expected %0d, got %0d", want.center_y, got.center_y);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        errors++;
      end
      degenerate_seen += want.degenerate;
      saturated_seen += want.saturated;
    endfunction
  endclass

  localparam int LATENCY   = tcl_pkg::COORD_WIDTH + tcl_pkg::BLEND_FRAC_BITS + 15;
  localparam int STALL_MAX = 10;
  localparam int IDLE_LIMIT = 20 * (LATENCY + STALL_MAX);
  localparam int RANDOM_REQUESTS = 1530;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tcl_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcl_pkg::out_t out_data;

  center_scoreboard sb = new();
  int  requests_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  no_gaps = 1'b0;

  triangle_center_lerp DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Drain results with random back-pressure after each one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen++;
      stall_left = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(tcl_pkg::in_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    requests_sent++;
  endtask

  function automatic tcl_pkg::in_t make_triangle(int ax, int ay, int bx, int by,
                                                 int cx, int cy, int bl);
    tcl_pkg::in_t r;
    r.a_x = ax[tcl_pkg::COORD_WIDTH-1:0]; r.a_y = ay[tcl_pkg::COORD_WIDTH-1:0];
    r.b_x = bx[tcl_pkg::COORD_WIDTH-1:0]; r.b_y = by[tcl_pkg::COORD_WIDTH-1:0];
    r.c_x = cx[tcl_pkg::COORD_WIDTH-1:0]; r.c_y = cy[tcl_pkg::COORD_WIDTH-1:0];
    r.blend = bl[tcl_pkg::BLEND_WIDTH-1:0];
    return r;
  endfunction

  function automatic int pick_blend();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return int'(tcl_pkg::BLEND_ONE);
      2: return $urandom_range(int'(tcl_pkg::BLEND_ONE) + 1,
                               2 * int'(tcl_pkg::BLEND_ONE) - 1);
      default: return $urandom_range(0, int'(tcl_pkg::BLEND_ONE));
    endcase
  endfunction

  function automatic int coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Random triangle: mostly well-spread, some collinear or nearly so
  function automatic tcl_pkg::in_t random_triangle();
    tcl_pkg::in_t r;
    int ax, ay, ux, uy, k;
    case ($urandom_range(0, 9)) inside
      [0:2]: r = make_triangle(coord(4096), coord(4096), coord(4096), coord(4096),
                               coord(4096), coord(4096), pick_blend());
      [3:4]: begin
        r = tcl_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r.blend = pick_blend();
      end
      5: begin
        ax = coord(1 << 20); ay = coord(1 << 20);
        ux = coord(1 << 18); uy = coord(1 << 18); k = coord(3);
        r = make_triangle(ax, ay, ax + ux, ay + uy, ax + k * ux, ay + k * uy, pick_blend());
      end
      6: begin
        ax = coord(1 << 20); ay = coord(1 << 20);
        ux = coord(1 << 18); uy = coord(1 << 18); k = coord(3);
        r = make_triangle(ax, ay, ax + ux, ay + uy, ax + k * ux + 1, ay + k * uy,
                          pick_blend());
      end
      default: r = make_triangle(coord(1 << 22), coord(1 << 22), coord(1 << 22),
                                 coord(1 << 22), coord(1 << 22), coord(1 << 22),
                                 pick_blend());
    endcase
    return r;
  endfunction

  initial begin
    int lo, hi, one;
    lo = -(1 << (tcl_pkg::COORD_WIDTH - 1));
    hi = (1 << (tcl_pkg::COORD_WIDTH - 1)) - 1;
    one = int'(tcl_pkg::BLEND_ONE);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero, extremes, blend end points, collinear, far centre
    send_request(make_triangle(0, 0, 0, 0, 0, 0, 0));
    send_request(make_triangle(0, 0, 256, 0, 0, 256, 0));
    send_request(make_triangle(0, 0, 256, 0, 0, 256, one));
    send_request(make_triangle(0, 0, 256, 0, 0, 256, one / 2));
    send_request(make_triangle(0, 0, 256, 0, 0, 256, 2 * one - 1));
    send_request(make_triangle(0, 0, 256, 0, 0, 256, one + 1));
    send_request(make_triangle(hi, hi, hi, hi, hi, hi, one));
    send_request(make_triangle(lo, lo, lo, lo, lo, lo, 0));
    send_request(make_triangle(lo, lo, hi, lo, lo, hi, 0));
    send_request(make_triangle(hi, hi, lo, hi, hi, lo, one));
    send_request(make_triangle(lo, hi, hi, lo, lo, lo, one / 3));
    send_request(make_triangle(hi, lo, lo, hi, hi, hi, 2 * one - 1));
    send_request(make_triangle(0, 0, 100, 100, 300, 300, one / 2));
    send_request(make_triangle(lo, lo, 0, 0, hi, hi, 0));
    send_request(make_triangle(-1, -1, 1, 1, 3, 3, one));
    send_request(make_triangle(0, 0, 1, 0, 2, 1, 0));
    send_request(make_triangle(lo, 0, hi, 0, 0, 1, 0));
    send_request(make_triangle(lo, 0, hi, 0, 0, 1, one));
    send_request(make_triangle(lo, 0, hi, 0, 0, 1, one - 1));
    send_request(make_triangle(-5, 7, 13, -2, 4, 9, 12345));

    // Random part, with gap-free stretches now and then
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_request(random_triangle());
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;

    // Drain, then allow for any late result
    while (sb.pending_centers.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (sb.pending_centers.size() != 0) begin
      $error("%0d results never arrived", sb.pending_centers.size());
      sb.errors++;
    end

    $display("%0d triangles sent, %0d centres checked", requests_sent, results_seen);
    $display("%0d collinear, %0d clipped", sb.degenerate_seen, sb.saturated_seen);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
